// File: hdl/sxt_pkg.sv
// Shared types and constants for the S-expression tokenizer.
package sxt_pkg;

   localparam int unsigned MAX_TOKEN_CHARS = 511;
   localparam int unsigned LEN_W = 10;

   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_VT     = 8'd11;
   localparam logic [7:0] CH_FF     = 8'd12;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_TICK   = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;

   typedef enum logic [2:0] {
      KIND_INT   = 3'd0,
      KIND_PUNCT = 3'd1,
      KIND_IDENT = 3'd2,
      KIND_STR   = 3'd3,
      KIND_EOI   = 3'd4
   } kind_type;

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_COMMENT = 6'b000010,
      MODE_INT     = 6'b000100,
      MODE_IDENT   = 6'b001000,
      MODE_STR     = 6'b010000,
      MODE_ESC     = 6'b100000
   } mode_type;

   typedef struct packed {
      mode_type         mode;
      logic             opened;
      logic [LEN_W-1:0] len;
      logic             ovf;
   } lex_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic       has;
      logic       start;
      logic       fin;
      logic       too_long;
      logic       unterm;
   } result_type;

endpackage

// File: hdl/sxt_lex_core.sv
// Next-state and result logic of the tokenizer for one source byte.
module sxt_lex_core (
   input  sxt_pkg::lex_state_type cur,
   input  logic [7:0]             in_char,
   input  logic                   at_end,
   output sxt_pkg::lex_state_type nxt,
   output logic [1:0]             res_cnt,
   output sxt_pkg::result_type    res0,
   output sxt_pkg::result_type    res1
);

   sxt_pkg::result_type res [2];
   logic                eoi;
   logic                close_req;
   sxt_pkg::kind_type   close_kind;
   logic                close_un;
   logic                do_idle;
   logic                push_req;
   sxt_pkg::kind_type   push_kind;
   logic [7:0]          push_ch;
   logic                is_digit;
   logic                is_blank;
   logic                is_punct;
   logic                ends_ident;
   logic [7:0]          esc_ch;

   localparam logic [sxt_pkg::LEN_W-1:0] MaxLen = sxt_pkg::LEN_W'(sxt_pkg::MAX_TOKEN_CHARS);

   always_comb begin
      is_digit = (in_char >= sxt_pkg::CH_ZERO) && (in_char <= sxt_pkg::CH_NINE);
      is_blank = (in_char == sxt_pkg::CH_SPACE) || (in_char == sxt_pkg::CH_TAB) ||
                 (in_char == sxt_pkg::CH_LF) || (in_char == sxt_pkg::CH_VT) ||
                 (in_char == sxt_pkg::CH_FF) || (in_char == sxt_pkg::CH_CR);
      is_punct = (in_char == sxt_pkg::CH_LPAREN) || (in_char == sxt_pkg::CH_RPAREN) ||
                 (in_char == sxt_pkg::CH_DOT) || (in_char == sxt_pkg::CH_TICK) ||
                 (in_char == sxt_pkg::CH_COMMA);
      ends_ident = is_punct || (in_char == sxt_pkg::CH_SEMI) ||
                   (in_char == sxt_pkg::CH_SPACE) || (in_char == sxt_pkg::CH_TAB) ||
                   (in_char == sxt_pkg::CH_LF);
      if (in_char == sxt_pkg::CH_LOW_T) begin
         esc_ch = sxt_pkg::CH_TAB;
      end else if (in_char == sxt_pkg::CH_LOW_N) begin
         esc_ch = sxt_pkg::CH_LF;
      end else begin
         esc_ch = in_char;
      end
   end

   always_comb begin
      eoi        = at_end || (in_char == 8'd0);
      nxt        = cur;
      res_cnt    = 2'd0;
      res[0]     = '0;
      res[1]     = '0;
      close_req  = 1'b0;
      close_kind = sxt_pkg::KIND_INT;
      close_un   = 1'b0;
      do_idle    = 1'b0;
      push_req   = 1'b0;
      push_kind  = sxt_pkg::KIND_INT;
      push_ch    = in_char;

      if (eoi) begin
         case (cur.mode)
            sxt_pkg::MODE_INT: begin
               close_req = 1'b1;
            end
            sxt_pkg::MODE_IDENT: begin
               close_req  = 1'b1;
               close_kind = sxt_pkg::KIND_IDENT;
            end
            sxt_pkg::MODE_STR, sxt_pkg::MODE_ESC: begin
               close_req  = 1'b1;
               close_kind = sxt_pkg::KIND_STR;
               close_un   = 1'b1;
            end
            default: ;
         endcase
      end else if (in_char != sxt_pkg::CH_CR) begin
         case (cur.mode)
            sxt_pkg::MODE_INT: begin
               if (is_digit) begin
                  push_req = 1'b1;
               end else begin
                  close_req = 1'b1;
                  do_idle   = 1'b1;
               end
            end
            sxt_pkg::MODE_IDENT: begin
               if (!ends_ident) begin
                  push_req  = 1'b1;
                  push_kind = sxt_pkg::KIND_IDENT;
               end else begin
                  close_req  = 1'b1;
                  close_kind = sxt_pkg::KIND_IDENT;
                  do_idle    = 1'b1;
               end
            end
            sxt_pkg::MODE_STR: begin
               if (in_char == sxt_pkg::CH_QUOTE) begin
                  close_req  = 1'b1;
                  close_kind = sxt_pkg::KIND_STR;
               end else if (in_char == sxt_pkg::CH_BSLASH) begin
                  nxt.mode = sxt_pkg::MODE_ESC;
               end else begin
                  push_req  = 1'b1;
                  push_kind = sxt_pkg::KIND_STR;
               end
            end
            sxt_pkg::MODE_ESC: begin
               nxt.mode  = sxt_pkg::MODE_STR;
               push_req  = 1'b1;
               push_kind = sxt_pkg::KIND_STR;
               push_ch   = esc_ch;
            end
            sxt_pkg::MODE_COMMENT: begin
               if (in_char == sxt_pkg::CH_LF) begin
                  nxt.mode = sxt_pkg::MODE_IDLE;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase
      end

      if (close_req) begin
         res[0] = '{kind: close_kind, ch: 8'd0, has: 1'b0, start: !cur.opened,
                    fin: 1'b1, too_long: cur.ovf, unterm: close_un};
         res_cnt    = 2'd1;
         nxt.mode   = sxt_pkg::MODE_IDLE;
         nxt.opened = 1'b0;
         nxt.len    = '0;
         nxt.ovf    = 1'b0;
      end

      if (do_idle) begin
         nxt.mode   = sxt_pkg::MODE_IDLE;
         nxt.opened = 1'b0;
         nxt.len    = '0;
         nxt.ovf    = 1'b0;
         if (is_blank) begin
            nxt.mode = sxt_pkg::MODE_IDLE;
         end else if (in_char == sxt_pkg::CH_SEMI) begin
            nxt.mode = sxt_pkg::MODE_COMMENT;
         end else if (is_digit) begin
            nxt.mode = sxt_pkg::MODE_INT;
            push_req = 1'b1;
         end else if (is_punct) begin
            res[res_cnt[0]] = '{kind: sxt_pkg::KIND_PUNCT, ch: in_char, has: 1'b1,
                                start: 1'b1, fin: 1'b1, too_long: 1'b0, unterm: 1'b0};
            res_cnt = res_cnt + 2'd1;
         end else if (in_char == sxt_pkg::CH_QUOTE) begin
            nxt.mode = sxt_pkg::MODE_STR;
         end else begin
            nxt.mode  = sxt_pkg::MODE_IDENT;
            push_req  = 1'b1;
            push_kind = sxt_pkg::KIND_IDENT;
         end
      end

      if (push_req) begin
         if (nxt.len < MaxLen) begin
            res[res_cnt[0]] = '{kind: push_kind, ch: push_ch, has: 1'b1,
                                start: !nxt.opened, fin: 1'b0, too_long: 1'b0,
                                unterm: 1'b0};
            res_cnt    = res_cnt + 2'd1;
            nxt.opened = 1'b1;
            nxt.len    = nxt.len + 1'b1;
         end else begin
            nxt.ovf = 1'b1;
         end
      end

      if (eoi) begin
         res[res_cnt[0]] = '{kind: sxt_pkg::KIND_EOI, ch: 8'd0, has: 1'b0, start: 1'b1,
                             fin: 1'b1, too_long: 1'b0, unterm: 1'b0};
         res_cnt    = res_cnt + 2'd1;
         nxt.mode   = sxt_pkg::MODE_IDLE;
         nxt.opened = 1'b0;
         nxt.len    = '0;
         nxt.ovf    = 1'b0;
      end

      res0 = res[0];
      res1 = res[1];
   end

endmodule

// File: hdl/sexpr_tokenizer_top.sv
// Top level of the S-expression tokenizer: request register, lexer state, result buffer.
//
//  channel  direction  tdata                        tuser                  tlast
//  req_     in         [7:0] in_char                -                      at_end
//  rsp_     out        [7:0] out_char, [8] start,   [2:0] kind, [3] has    token end
//                      [9] too_long, [10] unterm
//
// One request per cycle is taken while the result slots can accept it; a request's results
// are registered into the output slot when it is processed. A request with two results holds
// the request side while the second result drains from the pending slot.
// Synchronous active-high reset clears the lexer to idle and empties all stages.
// Stalls on rsp_ back up through the two result slots and the request register.
module sexpr_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tlast,   // at_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_char, [8] token_start, [9] too_long,
                                    // [10] unterminated, [15:11] zero
   output logic [3:0]  rsp_tuser,   // [2:0] token_kind, [3] has_char
   output logic        rsp_tlast    // token_end
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff, in_char_in;
   logic                   in_end_ff, in_end_in;
   sxt_pkg::lex_state_type lex_ff, lex_in;
   logic                   out_valid_ff, out_valid_in;
   sxt_pkg::result_type    out_ff, out_in;
   logic                   pend_valid_ff, pend_valid_in;
   sxt_pkg::result_type    pend_ff, pend_in;

   sxt_pkg::lex_state_type lex_nxt;
   logic [1:0]             res_cnt;
   sxt_pkg::result_type    res0, res1;
   logic                   proc;

   sxt_lex_core u_core (
      .cur     (lex_ff),
      .in_char (in_char_ff),
      .at_end  (in_end_ff),
      .nxt     (lex_nxt),
      .res_cnt (res_cnt),
      .res0    (res0),
      .res1    (res1)
   );

   assign proc       = in_valid_ff && !pend_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_end_in   = in_end_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
         in_end_in   = req_tlast;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end

      lex_in = proc ? lex_nxt : lex_ff;

      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (proc) begin
         out_valid_in  = (res_cnt != 2'd0);
         out_in        = res0;
         pend_valid_in = (res_cnt == 2'd2);
         pend_in       = res1;
      end else if (pend_valid_ff && rsp_tready) begin
         out_in        = pend_ff;
         pend_valid_in = 1'b0;
      end else if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         lex_ff        <= '{mode: sxt_pkg::MODE_IDLE, opened: 1'b0, len: '0, ovf: 1'b0};
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         lex_ff        <= lex_in;
      end
      in_char_ff <= in_char_in;
      in_end_ff  <= in_end_in;
      out_ff     <= out_in;
      pend_ff    <= pend_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.unterm, out_ff.too_long, out_ff.start, out_ff.ch};
   assign rsp_tuser  = {out_ff.has, out_ff.kind};
   assign rsp_tlast  = out_ff.fin;

endmodule

// File: tb/sv/tb_sexpr_tokenizer_top.sv
// Self-checking testbench for the S-expression tokenizer: directed table, random source text.
module tb_sexpr_tokenizer_top;
   import sxt_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
      logic       typed;
      result_type want;
   } lex_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   sexpr_tokenizer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("tb_sexpr_tokenizer_top: errors");
      $finish;
   end

   // lexer state mirror
   mode_type         lx_mode = MODE_IDLE;
   logic             lx_opened = 1'b0;
   logic [LEN_W-1:0] lx_len = '0;
   logic             lx_ovf = 1'b0;

   result_type token_results [$];

   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int phase_idx = -1;
   int seen_phase = -1;
   int hold_left = 0;
   int requests_sent = 0;
   int busy_requests = 0;
   int results_seen = 0;
   int tokens_closed = 0;
   int too_long_seen = 0;
   int unterm_seen = 0;
   int errors = 0;

   logic [7:0] punct_set [5] = '{CH_LPAREN, CH_RPAREN, CH_DOT, CH_TICK, CH_COMMA};
   logic [7:0] blank_set [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

   lex_row_type script [27] = '{
      '{CH_LPAREN, 1'b0, 1'b1, '{KIND_PUNCT, CH_LPAREN, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_RPAREN, 1'b0, 1'b1, '{KIND_PUNCT, CH_RPAREN, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_DOT,    1'b0, 1'b1, '{KIND_PUNCT, CH_DOT,    1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_TICK,   1'b0, 1'b1, '{KIND_PUNCT, CH_TICK,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_COMMA,  1'b0, 1'b1, '{KIND_PUNCT, CH_COMMA,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{8'hFF,     1'b1, 1'b1, '{KIND_EOI,   8'h00,     1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{8'h00,     1'b0, 1'b1, '{KIND_EOI,   8'h00,     1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_ZERO,   1'b0, 1'b0, '0},
      '{CH_NINE,   1'b0, 1'b0, '0},
      '{CH_SPACE,  1'b0, 1'b0, '0},
      '{CH_QUOTE,  1'b0, 1'b0, '0},
      '{CH_QUOTE,  1'b0, 1'b1, '{KIND_STR,   8'h00,     1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_QUOTE,  1'b0, 1'b0, '0},
      '{CH_BSLASH, 1'b0, 1'b0, '0},
      '{CH_LOW_T,  1'b0, 1'b0, '0},
      '{CH_BSLASH, 1'b0, 1'b0, '0},
      '{CH_LOW_N,  1'b0, 1'b0, '0},
      '{CH_CR,     1'b0, 1'b0, '0},
      '{CH_QUOTE,  1'b0, 1'b0, '0},
      '{CH_SEMI,   1'b0, 1'b0, '0},
      '{8'h61,     1'b0, 1'b0, '0},
      '{CH_LF,     1'b0, 1'b0, '0},
      '{8'hFF,     1'b0, 1'b0, '0},
      '{CH_SPACE,  1'b0, 1'b0, '0},
      '{CH_QUOTE,  1'b0, 1'b0, '0},
      '{8'h71,     1'b0, 1'b0, '0},
      '{8'h00,     1'b1, 1'b0, '0}
   };

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return c == CH_LPAREN || c == CH_RPAREN || c == CH_DOT || c == CH_TICK || c == CH_COMMA;
   endfunction

   function automatic logic ends_ident(input logic [7:0] c);
      return is_punct(c) || c == CH_SEMI || c == CH_SPACE || c == CH_TAB || c == CH_LF;
   endfunction

   function automatic void emit_token(input kind_type k, input logic [7:0] c, input logic h,
                                      input logic s, input logic f, input logic tl,
                                      input logic un);
      result_type r;
      r.kind = k;
      r.ch = h ? c : 8'h00;
      r.has = h;
      r.start = s;
      r.fin = f;
      r.too_long = tl;
      r.unterm = un;
      token_results.push_back(r);
   endfunction

   function automatic void clear_token();
      lx_opened = 1'b0;
      lx_len = '0;
      lx_ovf = 1'b0;
   endfunction

   function automatic int push_token_char(input kind_type k, input logic [7:0] c);
      if (lx_len < LEN_W'(MAX_TOKEN_CHARS)) begin
         emit_token(k, c, 1'b1, !lx_opened, 1'b0, 1'b0, 1'b0);
         lx_opened = 1'b1;
         lx_len = lx_len + 1'b1;
         return 1;
      end
      lx_ovf = 1'b1;
      return 0;
   endfunction

   function automatic int close_token(input kind_type k, input logic un);
      emit_token(k, 8'h00, 1'b0, !lx_opened, 1'b1, lx_ovf, un);
      clear_token();
      lx_mode = MODE_IDLE;
      return 1;
   endfunction

   function automatic int lex_from_idle(input logic [7:0] c);
      lx_mode = MODE_IDLE;
      clear_token();
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
         return 0;
      if (c == CH_SEMI) begin
         lx_mode = MODE_COMMENT;
         return 0;
      end
      if (is_digit(c)) begin
         lx_mode = MODE_INT;
         return push_token_char(KIND_INT, c);
      end
      if (is_punct(c)) begin
         emit_token(KIND_PUNCT, c, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
         return 1;
      end
      if (c == CH_QUOTE) begin
         lx_mode = MODE_STR;
         return 0;
      end
      lx_mode = MODE_IDENT;
      return push_token_char(KIND_IDENT, c);
   endfunction

   function automatic int lex_predict(input logic [7:0] c, input logic eoi);
      int n;
      n = 0;
      if (eoi || c == 8'h00) begin
         case (lx_mode)
            MODE_INT:          n = close_token(KIND_INT, 1'b0);
            MODE_IDENT:        n = close_token(KIND_IDENT, 1'b0);
            MODE_STR, MODE_ESC: n = close_token(KIND_STR, 1'b1);
            default: ;
         endcase
         lx_mode = MODE_IDLE;
         clear_token();
         emit_token(KIND_EOI, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
         return n + 1;
      end
      if (c == CH_CR)
         return 0;
      case (lx_mode)
         MODE_INT: begin
            if (is_digit(c))
               return push_token_char(KIND_INT, c);
            n = close_token(KIND_INT, 1'b0);
            return n + lex_from_idle(c);
         end
         MODE_IDENT: begin
            if (!ends_ident(c))
               return push_token_char(KIND_IDENT, c);
            n = close_token(KIND_IDENT, 1'b0);
            return n + lex_from_idle(c);
         end
         MODE_STR: begin
            if (c == CH_QUOTE)
               return close_token(KIND_STR, 1'b0);
            if (c == CH_BSLASH) begin
               lx_mode = MODE_ESC;
               return 0;
            end
            return push_token_char(KIND_STR, c);
         end
         MODE_ESC: begin
            lx_mode = MODE_STR;
            if (c == CH_LOW_T)
               c = CH_TAB;
            else if (c == CH_LOW_N)
               c = CH_LF;
            return push_token_char(KIND_STR, c);
         end
         MODE_COMMENT: begin
            if (c == CH_LF)
               lx_mode = MODE_IDLE;
            return 0;
         end
         default: return lex_from_idle(c);
      endcase
   endfunction

   task automatic offer_request(input logic [7:0] c, input logic eoi, input logic typed,
                                input result_type want);
      int depth;
      int n;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      depth = token_results.size();
      n = lex_predict(c, eoi);
      if (typed) begin
         while (token_results.size() > depth) void'(token_results.pop_back());
         token_results.push_back(want);
      end
      requests_sent++;
      if (n > 0 || lx_mode inside {MODE_INT, MODE_IDENT, MODE_STR, MODE_ESC})
         busy_requests++;
      @(negedge clock);
   endtask

   task automatic offer(input logic [7:0] c, input logic eoi);
      offer_request(c, eoi, 1'b0, '0);
   endtask

   function automatic logic [7:0] ident_body_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (ends_ident(c));
      return c;
   endfunction

   function automatic logic [7:0] string_body_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
      return c;
   endfunction

   task automatic send_random_token();
      int pick;
      int len;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 299) == 0) ? $urandom_range(505, 520) : $urandom_range(1, 8);
      if (pick < 12) begin
         repeat (len) offer(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      end else if (pick < 26) begin
         c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(60, 126));
         offer(c, 1'b0);
         repeat (len - 1) offer(ident_body_char(), 1'b0);
      end else if (pick < 38) begin
         offer(CH_QUOTE, 1'b0);
         repeat (len - 1) begin
            if ($urandom_range(0, 4) == 0) begin
               offer(CH_BSLASH, 1'b0);
               case ($urandom_range(0, 2))
                  0: offer(CH_LOW_T, 1'b0);
                  1: offer(CH_LOW_N, 1'b0);
                  default: offer(8'($urandom_range(1, 255)), 1'b0);
               endcase
            end else begin
               offer(string_body_char(), 1'b0);
            end
         end
         if ($urandom_range(0, 9) != 0)
            offer(CH_QUOTE, 1'b0);
      end else if (pick < 52) begin
         offer(punct_set[3'($urandom_range(0, 4))], 1'b0);
      end else if (pick < 66) begin
         repeat ($urandom_range(1, 3)) offer(blank_set[3'($urandom_range(0, 5))], 1'b0);
      end else if (pick < 73) begin
         offer(CH_SEMI, 1'b0);
         repeat ($urandom_range(0, 6)) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_LF);
            offer(c, 1'b0);
         end
         offer(CH_LF, 1'b0);
      end else if (pick < 79) begin
         if ($urandom_range(0, 1) == 0)
            offer(8'($urandom_range(0, 255)), 1'b1);
         else
            offer(8'h00, 1'b0);
      end else begin
         offer(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end
   endtask

   // hold off for a long stretch at the start of the unthrottled random phase
   always @(negedge clock) begin
      if (phase_idx != seen_phase) begin
         seen_phase = phase_idx;
         if (phase_idx == 0)
            hold_left = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = kind_type'(rsp_tuser[2:0]);
         got.has = rsp_tuser[3];
         got.ch = rsp_tdata[7:0];
         got.start = rsp_tdata[8];
         got.too_long = rsp_tdata[9];
         got.unterm = rsp_tdata[10];
         got.fin = rsp_tlast;
         results_seen++;
         if (got.fin) tokens_closed++;
         if (got.too_long) too_long_seen++;
         if (got.unterm) unterm_seen++;
         if (token_results.size() == 0) begin
            $error("token result with none expected: tdata %0h tuser %0h", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = token_results.pop_front();
            check_field("token_kind", int'(want.kind), int'(got.kind));
            check_field("out_char", int'(want.ch), int'(got.ch));
            check_field("has_char", int'(want.has), int'(got.has));
            check_field("token_start", int'(want.start), int'(got.start));
            check_field("token_end", int'(want.fin), int'(got.fin));
            check_field("too_long", int'(want.too_long), int'(got.too_long));
            check_field("unterminated", int'(want.unterm), int'(got.unterm));
         end
      end
   end

   initial begin
      int goal;
      int base;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      foreach (script[i])
         offer_request(script[i].ch, script[i].eoi, script[i].typed, script[i].want);
      // overflow an integer token past the character limit
      repeat (MAX_TOKEN_CHARS + 1) offer(CH_NINE, 1'b0);
      offer(CH_SPACE, 1'b0);
      base = requests_sent;
      for (int p = 0; p < 4; p++) begin
         phase_idx <= p;
         rx_stall_pct <= (p == 2) ? 74 : (p == 3) ? 29 : 0;
         tx_idle_pct = (p == 1) ? 74 : (p == 3) ? 29 : 0;
         goal = base + (1850 - base) * (p + 1) / 4;
         while (requests_sent < goal) send_random_token();
      end
      req_tvalid <= 1'b0;
      while (token_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("Lexed %0d request bytes, %0d of them inside tokens, over four idle/stall mixes.",
               requests_sent, busy_requests);
      $display("Checked %0d results: %0d tokens closed, %0d too long, %0d unterminated.",
               results_seen, tokens_closed, too_long_seen, unterm_seen);
      if (errors == 0)
         $display("tb_sexpr_tokenizer_top: clean");
      else
         $display("tb_sexpr_tokenizer_top: errors");
      $finish;
   end

endmodule
